// File: src/spd_pkg.sv
// spd_pkg: shared types and constants of the stuck position detector
// used by spd_axis, spd_update and stuck_position_detector_core; no dependencies
package spd_pkg;

    // field widths
    localparam int unsigned POS_W   = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned DIST_W  = POS_W + 2;
    localparam int unsigned DIFF_W  = POS_W + 1;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIST_THRESH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_THRESH = 1'd1;

    // smoothing: new = ref + floor((COEF_NEW * (pos - ref) + ROUND_HALF) / 2^FRAC_W)
    localparam int unsigned COEF_W     = 14;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned PROD_W     = DIFF_W + COEF_W;
    localparam logic signed [COEF_W-1:0] COEF_NEW   = 14'sd6554;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 47'sd32768;

    // configuration values seen by the datapath
    typedef struct packed {
        logic [POS_W-1:0]   dist_thr;
        logic [COUNT_W-1:0] count_thr;
    } cfg_t;

    // one sample handed to the update stage
    typedef struct packed {
        logic                    go;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } sample_t;

endpackage

// File: src/stuck_position_detector_core.sv
// stuck_position_detector_core: top level with input and result registers and config port
// depends on spd_pkg and spd_update
//
// Usage:
//   Input channel: in_valid / in_stall with pos_x, pos_y (signed Q16.16). A word is taken
//   at a clock edge where in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall with stuck. One result word per input word, in
//   order. A word is delivered at an edge where out_valid is high and out_stall is low.
//   Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is the
//   distance threshold (Q16.16), index 1 the count threshold. cfg_ready is always high.
//   Write config only while no word is in flight.
//   Path: an accepted word passes the input register, then the single-pass update into the
//   result register, where out_valid rises; a stall on the result side holds it back.
//   Throughput: one word per cycle while the receiver does not stall; the reference and
//   count recurrence closes in a single update through one multiplier per axis.
//   Stall: when the receiver stalls, the result register holds; an empty input register
//   still takes one more word, after which in_stall rises until the result drains.
//   Reset: thresholds, reference position and still count clear to zero; both
//   registers come up empty.
module stuck_position_detector_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [spd_pkg::POS_W-1:0]       pos_x,
    input  logic signed [spd_pkg::POS_W-1:0]       pos_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   stuck,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [spd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [spd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    spd_pkg::cfg_t                      cfg_reg;
    logic                               in_valid_reg;
    logic signed [spd_pkg::POS_W-1:0]   pos_x_reg;
    logic signed [spd_pkg::POS_W-1:0]   pos_y_reg;
    logic                               out_valid_reg;
    logic                               stuck_reg;
    logic                               stuck_next;
    logic                               out_free;
    logic                               advance;
    logic                               in_take;
    spd_pkg::sample_t                   smp;

    // handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                spd_pkg::CFG_DIST_THRESH:  cfg_reg.dist_thr  <= cfg_data;
                spd_pkg::CFG_COUNT_THRESH: cfg_reg.count_thr <= cfg_data[spd_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
        end
    end

    // single-pass update
    assign smp.go = advance;
    assign smp.x  = pos_x_reg;
    assign smp.y  = pos_y_reg;

    spd_update u_update
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .smp        (smp),
        .stuck_next (stuck_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stuck_reg <= stuck_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign stuck     = stuck_reg;

`ifndef SYNTH
    // the input register only stalls when it holds a word behind a full result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

    // a held result is never overwritten by a new update
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !advance)
        else $error("update while result is held");

    // a processed word shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && stuck_reg == $past(stuck_next))
        else $error("processed word did not reach the result register");
`endif

endmodule

// File: src/spd_axis.sv
// spd_axis: per-axis distance and smoothing arithmetic of the detector
// depends on spd_pkg
module spd_axis
(
    input  logic signed [spd_pkg::POS_W-1:0]  pos,
    input  logic signed [spd_pkg::POS_W-1:0]  ref_pos,
    output logic        [spd_pkg::DIFF_W-1:0] abs_diff,
    output logic signed [spd_pkg::POS_W-1:0]  smoothed
);

    logic signed [spd_pkg::DIFF_W-1:0] diff;
    logic signed [spd_pkg::PROD_W-1:0] prod;
    logic signed [spd_pkg::PROD_W-1:0] prod_rnd;
    logic signed [spd_pkg::DIFF_W-1:0] step;
    logic signed [spd_pkg::DIFF_W-1:0] sum;

    function automatic logic signed [spd_pkg::PROD_W-1:0] PROD_W_EXT
        (input logic signed [spd_pkg::DIFF_W-1:0] v);
        PROD_W_EXT = {{spd_pkg::COEF_W{v[spd_pkg::DIFF_W-1]}}, v};
    endfunction

    function automatic logic signed [spd_pkg::PROD_W-1:0] PROD_W_COEF();
        PROD_W_COEF = {{spd_pkg::DIFF_W{1'b0}}, spd_pkg::COEF_NEW};
    endfunction

    // exact difference and magnitude
    assign diff     = {pos[spd_pkg::POS_W-1], pos} - {ref_pos[spd_pkg::POS_W-1], ref_pos};
    assign abs_diff = diff[spd_pkg::DIFF_W-1] ? spd_pkg::DIFF_W'(-diff) : diff;

    // move a tenth of the way toward the sample, round half up
    assign prod     = PROD_W_EXT(diff) * PROD_W_COEF();
    assign prod_rnd = prod + spd_pkg::ROUND_HALF;
    assign step     = spd_pkg::DIFF_W'(prod_rnd >>> spd_pkg::FRAC_W);
    assign sum      = {ref_pos[spd_pkg::POS_W-1], ref_pos} + step;
    assign smoothed = sum[spd_pkg::POS_W-1:0];

endmodule

// File: src/spd_update.sv
// spd_update: reference position and still-count registers with the per-sample decision
// depends on spd_pkg and spd_axis
module spd_update
(
    input  logic              clk,
    input  logic              rst_n,
    input  spd_pkg::cfg_t     cfg,
    input  spd_pkg::sample_t  smp,
    output logic              stuck_next
);

    logic signed [spd_pkg::POS_W-1:0]   ref_x_reg;
    logic signed [spd_pkg::POS_W-1:0]   ref_y_reg;
    logic        [spd_pkg::COUNT_W-1:0] still_count_reg;
    logic signed [spd_pkg::POS_W-1:0]   ref_x_next;
    logic signed [spd_pkg::POS_W-1:0]   ref_y_next;
    logic        [spd_pkg::COUNT_W-1:0] still_count_next;

    logic        [spd_pkg::DIFF_W-1:0]  abs_x;
    logic        [spd_pkg::DIFF_W-1:0]  abs_y;
    logic signed [spd_pkg::POS_W-1:0]   smooth_x;
    logic signed [spd_pkg::POS_W-1:0]   smooth_y;
    logic        [spd_pkg::DIST_W-1:0]  manhattan;
    logic                               moving;
    logic        [spd_pkg::COUNT_W:0]   count_inc;
    logic                               over_count;

    // one lane per axis
    spd_axis u_axis_x
    (
        .pos      (smp.x),
        .ref_pos  (ref_x_reg),
        .abs_diff (abs_x),
        .smoothed (smooth_x)
    );

    spd_axis u_axis_y
    (
        .pos      (smp.y),
        .ref_pos  (ref_y_reg),
        .abs_diff (abs_y),
        .smoothed (smooth_y)
    );

    // manhattan distance against threshold
    assign manhattan = {1'b0, abs_x} + {1'b0, abs_y};
    assign moving    = manhattan > {2'b00, cfg.dist_thr};

    // still count with clamp at threshold
    assign count_inc  = {1'b0, still_count_reg} + 17'd1;
    assign over_count = count_inc > {1'b0, cfg.count_thr};

    // next state
    always_comb
    begin
        ref_x_next       = ref_x_reg;
        ref_y_next       = ref_y_reg;
        still_count_next = still_count_reg;
        stuck_next       = 1'b0;
        if (moving)
        begin
            ref_x_next       = smp.x;
            ref_y_next       = smp.y;
            still_count_next = '0;
        end
        else
        begin
            ref_x_next = smooth_x;
            ref_y_next = smooth_y;
            if (over_count)
            begin
                still_count_next = cfg.count_thr;
                stuck_next       = 1'b1;
            end
            else
            begin
                still_count_next = count_inc[spd_pkg::COUNT_W-1:0];
            end
        end
    end

    // state registers, updated once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg       <= '0;
            ref_y_reg       <= '0;
            still_count_reg <= '0;
        end
        else if (smp.go)
        begin
            ref_x_reg       <= ref_x_next;
            ref_y_reg       <= ref_y_next;
            still_count_reg <= still_count_next;
        end
    end

`ifndef SYNTH
    // a moving sample clears the count and snaps the reference
    a_move_clears: assert property (@(posedge clk) disable iff (!rst_n)
        smp.go && moving |=> still_count_reg == '0 && ref_x_reg == $past(smp.x)
            && ref_y_reg == $past(smp.y))
        else $error("moving sample did not reset reference and count");

    // a stuck result leaves the count at the threshold
    a_stuck_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        smp.go && stuck_next |=> still_count_reg == $past(cfg.count_thr))
        else $error("stuck result without clamped count");

    // a still sample that is not stuck advances the count by one
    a_still_counts: assert property (@(posedge clk) disable iff (!rst_n)
        smp.go && !moving && !stuck_next |=>
            still_count_reg == $past(still_count_reg) + 16'd1)
        else $error("still count did not advance");
`endif

endmodule

// File: sim/spd_stuck_checker.sv
`timescale 1ns / 1ps
// spd_stuck_checker: watches the sample, result and config channels of the stuck position
// detector, predicts the stuck flag of every sample and compares it with each result word
// depends on spd_pkg
module spd_stuck_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic signed [spd_pkg::POS_W-1:0]       pos_x,
    input  logic signed [spd_pkg::POS_W-1:0]       pos_y,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic                                   stuck,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic        [spd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [spd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                     fail_count,
    output int                                     words_due
);

    // smoothing weights: 0.1 toward the sample, 0.9 kept from the reference
    localparam longint SAMPLE_WEIGHT = longint'(spd_pkg::COEF_NEW);
    localparam longint ANCHOR_WEIGHT = (longint'(1) << spd_pkg::FRAC_W) - SAMPLE_WEIGHT;
    localparam longint ROUND_UP      = longint'(1) << (spd_pkg::FRAC_W - 1);

    // shadow of the thresholds and of the tracked position
    logic [spd_pkg::POS_W-1:0]          dist_limit;
    logic [spd_pkg::COUNT_W-1:0]        count_limit;
    logic signed [spd_pkg::POS_W-1:0]   anchor_x;
    logic signed [spd_pkg::POS_W-1:0]   anchor_y;
    logic [spd_pkg::COUNT_W-1:0]        still_run;
    bit                                 stuck_due[$];

    // exact absolute difference of two positions
    function automatic longint axis_gap(input logic signed [spd_pkg::POS_W-1:0] a,
                                        input logic signed [spd_pkg::POS_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? -d : d;
    endfunction

    // weighted move of the reference toward the sample, rounded half up
    function automatic logic signed [spd_pkg::POS_W-1:0] glide(
        input logic signed [spd_pkg::POS_W-1:0] sample,
        input logic signed [spd_pkg::POS_W-1:0] anchor);
        longint acc;
        acc = longint'(sample) * SAMPLE_WEIGHT + longint'(anchor) * ANCHOR_WEIGHT + ROUND_UP;
        acc = acc >>> spd_pkg::FRAC_W;
        return acc[spd_pkg::POS_W-1:0];
    endfunction

    // advance the shadow state by one sample and return its stuck flag
    function automatic bit judge_sample(input logic signed [spd_pkg::POS_W-1:0] x,
                                        input logic signed [spd_pkg::POS_W-1:0] y);
        longint                      gap_sum;
        logic [spd_pkg::COUNT_W:0]   bumped;
        bit                          flag;
        gap_sum = axis_gap(x, anchor_x) + axis_gap(y, anchor_y);
        flag = 1'b0;
        if (gap_sum > longint'(dist_limit))
        begin
            anchor_x  = x;
            anchor_y  = y;
            still_run = '0;
        end
        else
        begin
            bumped   = {1'b0, still_run} + 1'b1;
            anchor_x = glide(x, anchor_x);
            anchor_y = glide(y, anchor_y);
            if (bumped > {1'b0, count_limit})
            begin
                still_run = count_limit;
                flag      = 1'b1;
            end
            else
            begin
                still_run = bumped[spd_pkg::COUNT_W-1:0];
            end
        end
        return flag;
    endfunction

    // channel monitor: config writes, result compare, then new predictions
    always @(posedge clk or negedge rst_n)
    begin : watch
        bit want;
        if (!rst_n)
        begin
            dist_limit  = '0;
            count_limit = '0;
            anchor_x    = '0;
            anchor_y    = '0;
            still_run   = '0;
            stuck_due.delete();
            fail_count <= 0;
            words_due  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    spd_pkg::CFG_DIST_THRESH:  dist_limit  = cfg_data[spd_pkg::POS_W-1:0];
                    spd_pkg::CFG_COUNT_THRESH: count_limit = cfg_data[spd_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (stuck_due.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, expected none, got stuck=%0b",
                             $time, stuck);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = stuck_due.pop_front();
                    if (stuck !== want)
                    begin
                        $display("%0t: stuck mismatch, expected %0b, got %0b",
                                 $time, want, stuck);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                stuck_due.push_back(judge_sample(pos_x, pos_y));
            words_due <= stuck_due.size();
        end
    end

endmodule

// File: sim/stuck_position_detector_core_tb.sv
`timescale 1ns / 1ps
// stuck_position_detector_core_tb: drives samples, threshold writes and result stalls
// into the stuck position detector; depends on spd_pkg, spd_stuck_checker and the core
module stuck_position_detector_core_tb;

    localparam int RANDOM_WORDS = 1050;
    localparam int LONG_RUN     = 40;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_stall;
    logic signed [spd_pkg::POS_W-1:0]       pos_x;
    logic signed [spd_pkg::POS_W-1:0]       pos_y;
    logic                                   out_valid;
    logic                                   out_stall;
    logic                                   stuck;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic [spd_pkg::CFG_INDEX_W-1:0]        cfg_index;
    logic [spd_pkg::CFG_DATA_W-1:0]         cfg_data;
    int                                     fail_count;
    int                                     words_due;
    bit                                     feed_gaps;
    bit                                     drain_gaps;

    stuck_position_detector_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stuck     (stuck),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    spd_stuck_checker checker_inst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .stuck      (stuck),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard stop if the run hangs
    initial
    begin
        #8ms;
        $display("stuck_position_detector_core verification failed");
        $finish;
    end

    // result side: random stall before each word
    initial
    begin : result_drain
        int hold;
        out_stall = 1'b0;
        forever
        begin
            hold = drain_gaps ? $urandom_range(0, 19) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // offer one sample word, after a random gap, and wait until it is taken
    task automatic offer_sample(input logic signed [spd_pkg::POS_W-1:0] x,
                                input logic signed [spd_pkg::POS_W-1:0] y);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= x;
        pos_y    <= y;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // drop valid and wait until every result word has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
    endtask

    // write both thresholds; junk above the count width must be ignored
    task automatic set_thresholds(input logic [spd_pkg::POS_W-1:0] move_limit,
                                  input logic [spd_pkg::COUNT_W-1:0] count);
        cfg_valid <= 1'b1;
        cfg_index <= spd_pkg::CFG_DIST_THRESH;
        cfg_data  <= move_limit;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= spd_pkg::CFG_COUNT_THRESH;
        cfg_data  <= {16'($urandom()), count};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [spd_pkg::POS_W-1:0]          dthr;
        logic [spd_pkg::COUNT_W-1:0]        cthr;
        logic signed [spd_pkg::POS_W-1:0]   px_max;
        logic signed [spd_pkg::POS_W-1:0]   px_min;
        longint                             cx;
        longint                             cy;
        longint                             span;
        int                                 len;
        int                                 kind;
        int                                 sent;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        pos_x      = '0;
        pos_y      = '0;
        cfg_valid  = 1'b0;
        cfg_index  = spd_pkg::CFG_DIST_THRESH;
        cfg_data   = '0;
        feed_gaps  = 1'b0;
        drain_gaps = 1'b0;
        px_max     = 32'sh7FFF_FFFF;
        px_min     = 32'sh8000_0000;
        sent       = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: zero count threshold reports stuck on the first still word
        offer_sample(0, 0);
        offer_sample(32'sd1, 0);
        offer_sample(32'sd1, 0);
        settle();

        // widest distance threshold with extreme positions, including an exact tie
        set_thresholds(32'hFFFF_FFFF, 16'd3);
        feed_gaps  = 1'b1;
        drain_gaps = 1'b1;
        offer_sample(px_max, px_max);
        offer_sample(px_min, px_min);
        offer_sample(px_max, px_min);
        offer_sample(px_min, px_max);
        offer_sample(0, 0);
        settle();

        // one unit threshold: just above moves, exactly at stays still
        set_thresholds(32'h0001_0000, 16'd2);
        offer_sample(32'sh0005_0000, -32'sh0003_0000);
        offer_sample(32'sh0006_0001, -32'sh0003_0000);
        offer_sample(32'sh0005_8001, -32'sh0002_8000);
        offer_sample(32'sh0005_8001, -32'sh0002_8000);
        offer_sample(32'sh0005_8001, -32'sh0002_8000);
        offer_sample(32'sh0005_8001, -32'sh0002_8000);
        settle();

        // count threshold lowered while counting
        set_thresholds(32'h0010_0000, 16'd1000);
        repeat (8) offer_sample(32'sh0000_0123, -32'sh0000_0456);
        settle();
        set_thresholds(32'h0010_0000, 16'd2);
        offer_sample(32'sh0000_0123, -32'sh0000_0456);
        offer_sample(32'sh0000_0124, -32'sh0000_0455);
        settle();

        // long still run past the count threshold, count held at the top
        set_thresholds(32'hFFFF_FFFF, 16'd30);
        feed_gaps  = 1'b0;
        drain_gaps = 1'b0;
        repeat (LONG_RUN)
            offer_sample(32'sh0000_7000 + $urandom_range(0, 3),
                         -32'sh0000_7000 + $urandom_range(0, 3));
        settle();

        // random phases: settle near a point with small jitter, with jumps and noise
        while (sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 5))
                0:       dthr = '0;
                1:       dthr = 32'hFFFF_FFFF;
                2:       dthr = $urandom_range(1, 32'h0004_0000);
                3:       dthr = $urandom();
                default: dthr = $urandom_range(32'h0000_0100, 32'h0010_0000);
            endcase
            case ($urandom_range(0, 5))
                0:       cthr = '0;
                1:       cthr = 16'hFFFF;
                2:       cthr = 16'($urandom_range(1, 4));
                3:       cthr = 16'($urandom());
                default: cthr = 16'($urandom_range(0, 12));
            endcase
            feed_gaps  = ($urandom_range(0, 3) != 0);
            drain_gaps = ($urandom_range(0, 3) != 0);
            set_thresholds(dthr, cthr);
            span = longint'(dthr) / 6;
            cx   = longint'($signed(32'($urandom())));
            cy   = longint'($signed(32'($urandom())));
            len  = $urandom_range(15, 60);
            repeat (len)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 85)
                begin
                    offer_sample(32'(cx + longint'($urandom_range(0, 32'(2 * span))) - span),
                                 32'(cy + longint'($urandom_range(0, 32'(2 * span))) - span));
                end
                else if (kind < 95)
                begin
                    cx = longint'($signed(32'($urandom())));
                    cy = longint'($signed(32'($urandom())));
                    offer_sample(32'(cx), 32'(cy));
                end
                else
                begin
                    offer_sample($urandom(), $urandom());
                end
                sent++;
            end
            settle();
        end

        // let the pipeline go quiet, then report
        repeat (10) @(posedge clk);
        if (fail_count == 0 && words_due == 0)
            $display("stuck_position_detector_core verification clean");
        else
            $display("stuck_position_detector_core verification failed");
        $finish;
    end

endmodule

// File: files.f
src/spd_pkg.sv
src/spd_axis.sv
src/spd_update.sv
src/stuck_position_detector_core.sv
sim/spd_stuck_checker.sv
sim/stuck_position_detector_core_tb.sv
